/* rtl/core/wsp_pkg.sv */
package wsp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int VIEW_W     = 14;
    localparam int NUM_COLS   = 3;
    localparam int NUM_CFG    = 6;
    localparam int CLIP_W     = 48;
    localparam int NUM_W      = CLIP_W + 1;
    localparam int PROD_W     = NUM_W + VIEW_W;
    localparam int DEN_W      = CLIP_W + 2;
    localparam int QUO_W      = 33;
    localparam int OFF_W      = QUO_W + 3;
    localparam int OFFSET_X   = 105;
    localparam int OFFSET_Y   = -50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_X_UP = 4'd0,
        CFG_COL_X_LO = 4'd1,
        CFG_COL_Y_UP = 4'd2,
        CFG_COL_Y_LO = 4'd3,
        CFG_COL_W_UP = 4'd4,
        CFG_COL_W_LO = 4'd5,
        CFG_VIEW_W   = 4'd6,
        CFG_VIEW_H   = 4'd7
    } t_cfg_idx;

endpackage

/* rtl/core/wsp_clip.sv */
module wsp_clip #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [wsp_pkg::COORD_W-1:0]     i_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]     i_y,
    input  logic signed [wsp_pkg::COORD_W-1:0]     i_z,
    input  logic        [wsp_pkg::CFG_DATA_W-1:0]  i_col [wsp_pkg::NUM_CFG],
    output logic                                   o_valid,
    output logic signed [wsp_pkg::CLIP_W-1:0]      o_clip [wsp_pkg::NUM_COLS]
);
    import wsp_pkg::*;

    localparam int SUM_W = 2 * COORD_W + 2;
    localparam logic signed [SUM_W-1:0] CLIP_MAX = (SUM_W'(1) <<< (CLIP_W - 1)) - SUM_W'(1);

    logic signed [2*COORD_W-1:0] r_prod  [NUM_COLS][3];
    logic signed [COORD_W-1:0]   r_const [NUM_COLS];
    logic                        r_v1;
    logic                        r_v2;
    logic signed [CLIP_W-1:0]    r_clip  [NUM_COLS];
    logic signed [SUM_W-1:0]     n_sum   [NUM_COLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[c][0] <= i_x * $signed(i_col[2*c][63:32]);
                r_prod[c][1] <= i_y * $signed(i_col[2*c][31:0]);
                r_prod[c][2] <= i_z * $signed(i_col[2*c+1][63:32]);
                r_const[c]   <= $signed(i_col[2*c+1][31:0]);
            end
        end

        always_comb begin
            n_sum[c] = (SUM_W'(r_prod[c][0]) >>> COORD_FRAC_BITS)
                     + (SUM_W'(r_prod[c][1]) >>> COORD_FRAC_BITS)
                     + (SUM_W'(r_prod[c][2]) >>> COORD_FRAC_BITS)
                     + SUM_W'(r_const[c]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_sum[c] > CLIP_MAX) begin
                    r_clip[c] <= CLIP_MAX[CLIP_W-1:0];
                end else if (n_sum[c] < -CLIP_MAX) begin
                    r_clip[c] <= -CLIP_MAX[CLIP_W-1:0];
                end else begin
                    r_clip[c] <= n_sum[c][CLIP_W-1:0];
                end
            end
        end

        assign o_clip[c] = r_clip[c];
    end

    assign o_valid = r_v2;

    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clip[2] != {1'b1, {(CLIP_W-1){1'b0}}}))
        else $error("clip w outside saturation range");

endmodule

/* rtl/core/wsp_div.sv */
module wsp_div #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [wsp_pkg::PROD_W-1:0]    i_n,
    input  logic [wsp_pkg::DEN_W-1:0]     i_d,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [wsp_pkg::QUO_W-1:0]     o_q,
    output logic                          o_ovf,
    output logic [SIDE_W-1:0]             o_side
);
    import wsp_pkg::*;

    localparam int SH   = QUO_W - COORD_FRAC_BITS;
    localparam int NF_W = PROD_W + COORD_FRAC_BITS;
    localparam int CMP_W = DEN_W + SH + 1;

    logic [NF_W-1:0]   n_full;
    logic              n_ovf;

    logic [DEN_W-1:0]  r_rem  [QUO_W+1];
    logic [QUO_W-1:0]  r_low  [QUO_W+1];
    logic [QUO_W-1:0]  r_q    [QUO_W+1];
    logic [DEN_W-1:0]  r_d    [QUO_W+1];
    logic [SIDE_W-1:0] r_side [QUO_W+1];
    logic              r_ovf  [QUO_W+1];
    logic              r_vld  [QUO_W+1];

    assign n_full = {i_n, {COORD_FRAC_BITS{1'b0}}};
    assign n_ovf  = ((CMP_W > PROD_W ? CMP_W : PROD_W)'(i_n))
                 >= ((CMP_W > PROD_W ? CMP_W : PROD_W)'(i_d) << SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DEN_W'(n_full >> QUO_W);
            r_low[0]  <= n_full[QUO_W-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= i_d;
            r_side[0] <= i_side;
            r_ovf[0]  <= n_ovf;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] t;
        logic           ge;
        assign t  = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign ge = t >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DEN_W'(t - {1'b0, r_d[k-1]}) : DEN_W'(t);
                r_low[k]  <= {r_low[k-1][QUO_W-2:0], 1'b0};
                r_q[k]    <= {r_q[k-1][QUO_W-2:0], ge};
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
                r_ovf[k]  <= r_ovf[k-1];
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_q     = r_q[QUO_W];
    assign o_ovf   = r_ovf[QUO_W];
    assign o_side  = r_side[QUO_W];

    a_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ovf && (r_d[QUO_W] != '0)) |-> (r_rem[QUO_W] < r_d[QUO_W]))
        else $error("divider remainder not below divisor");

endmodule

/* rtl/core/world_to_screen_projection_core.sv */
// World point to screen projection, one item per clock while not stalled.
// Input channel: i_valid / o_stall with i_pos_x, i_pos_y, i_pos_z (signed fixed
// point, COORD_FRAC_BITS fraction bits). An item is taken when i_valid is high
// and o_stall is low.
// Output channel: o_valid / i_stall with o_screen_x, o_screen_y, o_w_zero.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
// o_cfg_ready is always high. Write only while no item is in flight.
// The pipeline holds the matrix products, the sums with saturation, numerator and
// denominator setup, a one-bit-per-stage restoring divider for each axis, and one
// output register. Throughput is one item per cycle when the output side does not
// stall.
// Reset clears all valid bits and loads the identity matrix and a 1280x720
// viewport. An output stall with o_valid high freezes every stage together;
// o_stall then rises in the same cycle, and no item is lost or repeated.
module world_to_screen_projection_core #(
    parameter int COORD_FRAC_BITS = wsp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [wsp_pkg::COORD_W-1:0]    i_pos_x,
    input  logic signed [wsp_pkg::COORD_W-1:0]    i_pos_y,
    input  logic signed [wsp_pkg::COORD_W-1:0]    i_pos_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [wsp_pkg::COORD_W-1:0]    o_screen_x,
    output logic signed [wsp_pkg::COORD_W-1:0]    o_screen_y,
    output logic                                  o_w_zero,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import wsp_pkg::*;

    localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << COORD_FRAC_BITS;
    localparam logic signed [OFF_W-1:0] OFF_X = OFF_W'(OFFSET_X) <<< COORD_FRAC_BITS;
    localparam logic signed [OFF_W-1:0] OFF_Y = OFF_W'(OFFSET_Y) <<< COORD_FRAC_BITS;
    localparam logic signed [OFF_W-1:0] S_MAX = OFF_W'(32'sh7FFF_FFFF);
    localparam logic signed [OFF_W-1:0] S_MIN = -OFF_W'(33'sh0_8000_0000);

    logic                  en;
    logic [CFG_DATA_W-1:0] r_col [NUM_CFG];
    logic [VIEW_W-1:0]     r_view_w;
    logic [VIEW_W-1:0]     r_view_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= ONE << 32;
            r_col[1] <= '0;
            r_col[2] <= ONE;
            r_col[3] <= '0;
            r_col[4] <= '0;
            r_col[5] <= ONE;
            r_view_w <= VIEW_W'(1280);
            r_view_h <= VIEW_W'(720);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COL_X_UP: r_col[0] <= i_cfg_data;
                CFG_COL_X_LO: r_col[1] <= i_cfg_data;
                CFG_COL_Y_UP: r_col[2] <= i_cfg_data;
                CFG_COL_Y_LO: r_col[3] <= i_cfg_data;
                CFG_COL_W_UP: r_col[4] <= i_cfg_data;
                CFG_COL_W_LO: r_col[5] <= i_cfg_data;
                CFG_VIEW_W:   r_view_w <= i_cfg_data[VIEW_W-1:0];
                CFG_VIEW_H:   r_view_h <= i_cfg_data[VIEW_W-1:0];
                default: ;
            endcase
        end
    end

    logic                     r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    logic                     clip_valid;
    logic signed [CLIP_W-1:0] clip [NUM_COLS];

    wsp_clip #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (i_pos_x),
        .i_y     (i_pos_y),
        .i_z     (i_pos_z),
        .i_col   (r_col),
        .o_valid (clip_valid),
        .o_clip  (clip)
    );

    // numerator and denominator setup
    logic signed [NUM_W-1:0] num_x, num_y;
    logic [NUM_W-1:0]        mag_x, mag_y;
    logic [CLIP_W-1:0]       mag_w;
    logic                    r3_valid, r3_wz, r3_neg_x, r3_neg_y;
    logic [PROD_W-1:0]       r3_n_x, r3_n_y;
    logic [DEN_W-1:0]        r3_d;

    assign num_x = NUM_W'(clip[0]) + NUM_W'(clip[2]);
    assign num_y = NUM_W'(clip[2]) - NUM_W'(clip[1]);
    assign mag_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
    assign mag_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
    assign mag_w = clip[2][CLIP_W-1] ? CLIP_W'(-clip[2]) : CLIP_W'(clip[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= clip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_n_x   <= PROD_W'(mag_x) * PROD_W'(r_view_w);
            r3_n_y   <= PROD_W'(mag_y) * PROD_W'(r_view_h);
            r3_d     <= {1'b0, mag_w, 1'b0};
            r3_wz    <= (clip[2] == '0);
            r3_neg_x <= num_x[NUM_W-1] ^ clip[2][CLIP_W-1];
            r3_neg_y <= num_y[NUM_W-1] ^ clip[2][CLIP_W-1];
        end
    end

    logic             dx_valid, dy_valid, dx_ovf, dy_ovf;
    logic [QUO_W-1:0] dx_q, dy_q;
    logic [1:0]       dx_side;
    logic [0:0]       dy_side;

    wsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SIDE_W(2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_n     (r3_n_x),
        .i_d     (r3_d),
        .i_side  ({r3_wz, r3_neg_x}),
        .o_valid (dx_valid),
        .o_q     (dx_q),
        .o_ovf   (dx_ovf),
        .o_side  (dx_side)
    );

    wsp_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SIDE_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_n     (r3_n_y),
        .i_d     (r3_d),
        .i_side  (r3_neg_y),
        .o_valid (dy_valid),
        .o_q     (dy_q),
        .o_ovf   (dy_ovf),
        .o_side  (dy_side)
    );

    // sign, offset, saturate; zero output when w is zero
    logic signed [OFF_W-1:0] sx, sy;
    logic signed [COORD_W-1:0] n_x, n_y;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic                      r_wz;

    assign sx = (dx_side[0] ? -$signed(OFF_W'(dx_q)) : $signed(OFF_W'(dx_q))) + OFF_X;
    assign sy = (dy_side[0] ? -$signed(OFF_W'(dy_q)) : $signed(OFF_W'(dy_q))) + OFF_Y;

    always_comb begin
        priority if (dx_side[1]) begin
            n_x = '0;
        end else if (dx_ovf) begin
            n_x = dx_side[0] ? S_MIN[COORD_W-1:0] : S_MAX[COORD_W-1:0];
        end else if (sx > S_MAX) begin
            n_x = S_MAX[COORD_W-1:0];
        end else if (sx < S_MIN) begin
            n_x = S_MIN[COORD_W-1:0];
        end else begin
            n_x = sx[COORD_W-1:0];
        end
        priority if (dx_side[1]) begin
            n_y = '0;
        end else if (dy_ovf) begin
            n_y = dy_side[0] ? S_MIN[COORD_W-1:0] : S_MAX[COORD_W-1:0];
        end else if (sy > S_MAX) begin
            n_y = S_MAX[COORD_W-1:0];
        end else if (sy < S_MIN) begin
            n_y = S_MIN[COORD_W-1:0];
        end else begin
            n_y = sy[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_wz <= dx_side[1];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_screen_x = r_x;
    assign o_screen_y = r_y;
    assign o_w_zero   = r_wz;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_valid == dy_valid)
        else $error("divider lanes out of step");

    a_wz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_w_zero) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("zero w item with nonzero screen position");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

endmodule
